[rtl/hcbp_pkg.sv]
// hcbp_pkg: shared types and constants for the huffman code bit packer
// used by every module of the block and by its checker; no dependencies
package hcbp_pkg;

    // table and code sizes
    localparam int HCBP_SYMBOL_COUNT = 256;
    localparam int HCBP_MAX_CODE_LEN = 32;
    localparam int HCBP_WORD_W       = 32;
    localparam int HCBP_LEN_W        = 6;
    // longest code actually kept: code field width or length limit, whichever is less
    localparam int HCBP_LEN_CAP      = (HCBP_MAX_CODE_LEN < HCBP_WORD_W) ?
                                       HCBP_MAX_CODE_LEN : HCBP_WORD_W;

    // item functions
    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ENCODE = 2'd1,
        FUNC_FLUSH  = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    // input item
    typedef struct packed {
        logic [1:0]             func;
        logic [7:0]             symbol;
        logic [HCBP_WORD_W-1:0] code_bits;
        logic [HCBP_LEN_W-1:0]  code_len;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // one code table entry
    typedef struct packed {
        logic [HCBP_LEN_W-1:0]  code_len;
        logic [HCBP_WORD_W-1:0] code_word;
    } t_code_entry;

    // registered table lookup handed to the packer
    typedef struct packed {
        logic        hit;
        t_code_entry entry;
    } t_tbl_rd;

endpackage

[rtl/hcbp_code_table.sv]
// hcbp_code_table: code word / length memory with per-entry valid bits
// depends on hcbp_pkg; read data is registered, invalid or out-of-range entries read with hit low
module hcbp_code_table #(
    parameter int SYMBOL_COUNT = hcbp_pkg::HCBP_SYMBOL_COUNT,
    parameter int AW           = $clog2(SYMBOL_COUNT)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  hcbp_pkg::t_code_entry i_wr_entry,
    input  logic                  i_rd_en,
    input  logic                  i_rd_ok,
    input  logic [AW-1:0]         i_rd_addr,
    output hcbp_pkg::t_tbl_rd     o_rd
);
    import hcbp_pkg::*;

    t_code_entry             r_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_valid;
    t_code_entry             r_rd_entry;
    logic                    r_rd_hit;

    // valid bits, cleared together at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    // memory read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
            r_rd_hit   <= i_rd_ok && r_valid[i_rd_addr];
        end
    end

    assign o_rd.hit   = r_rd_hit;
    assign o_rd.entry = r_rd_entry;

endmodule

[rtl/hcbp_packer.sv]
// hcbp_packer: bit accumulator and byte output register
// depends on hcbp_pkg; takes the staged function and table lookup, emits bytes msb-first
module hcbp_packer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s1_valid,
    input  hcbp_pkg::t_func     i_func,
    input  hcbp_pkg::t_tbl_rd   i_tbl,
    output logic                o_adv,
    output logic                o_valid,
    input  logic                i_stall,
    output hcbp_pkg::t_out_item o_item
);
    import hcbp_pkg::*;

    logic [6:0]            r_pend_bits;
    logic [2:0]            r_pend_cnt;
    logic [31:0]           r_obuf;
    logic [2:0]            r_ocnt;

    logic [6:0]            n_pend_bits;
    logic [2:0]            n_pend_cnt;
    logic [2:0]            nbytes;
    logic [31:0]           bytes32;
    logic [31:0]           obuf_new;
    logic [HCBP_LEN_W-1:0] eff_len;
    logic [38:0]           acc;
    logic [31:0]           whole;
    logic [HCBP_LEN_W-1:0] total;
    logic [2:0]            rem;
    logic [7:0]            flush_byte;
    logic                  emit_free;
    logic                  out_xfer;

    // append code bits to pending bits and split off whole bytes; a flush pads pending bits to a byte
    always_comb begin
        eff_len     = i_tbl.hit ? i_tbl.entry.code_len : '0;
        acc         = (39'(r_pend_bits) << eff_len) | 39'(i_tbl.entry.code_word);
        total       = HCBP_LEN_W'(r_pend_cnt) + eff_len;
        rem         = total[2:0];
        whole       = 32'(acc >> rem);
        flush_byte  = 8'(15'(r_pend_bits) << (4'd8 - 4'(r_pend_cnt)));
        nbytes      = '0;
        bytes32     = '0;
        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        case (i_func)
            FUNC_ENCODE: begin
                if (eff_len != '0) begin
                    nbytes      = total[5:3];
                    bytes32     = whole;
                    n_pend_bits = acc[6:0] & 7'((8'd1 << rem) - 8'd1);
                    n_pend_cnt  = rem;
                end
            end
            FUNC_FLUSH: begin
                if (r_pend_cnt != '0) begin
                    nbytes      = 3'd1;
                    bytes32     = {24'd0, flush_byte};
                    n_pend_bits = '0;
                    n_pend_cnt  = '0;
                end
            end
            default: begin
                nbytes = '0;
            end
        endcase
        // left-align the new bytes so the earliest sits in the top byte
        obuf_new = bytes32 << {3'd4 - nbytes, 3'b000};
    end

    // handshake between staged item and output register
    assign out_xfer  = o_valid && !i_stall;
    assign emit_free = (r_ocnt == '0) || ((r_ocnt == 3'd1) && out_xfer);
    assign o_adv     = i_s1_valid && ((nbytes == '0) || emit_free);

    // pending bit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else if (o_adv) begin
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
        end
    end

    // output byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= '0;
        end else if (o_adv && (nbytes != '0)) begin
            r_ocnt <= nbytes;
        end else if (out_xfer) begin
            r_ocnt <= r_ocnt - 3'd1;
        end
    end

    // output byte buffer
    always_ff @(posedge i_clk) begin
        if (o_adv && (nbytes != '0)) begin
            r_obuf <= obuf_new;
        end else if (out_xfer) begin
            r_obuf <= {r_obuf[23:0], 8'd0};
        end
    end

    assign o_valid         = (r_ocnt != '0);
    assign o_item.out_byte = r_obuf[31:24];
    assign o_item.last     = (r_ocnt == 3'd1);

endmodule

[rtl/huffman_code_bit_packer.sv]
// huffman code bit packer top level: input stage, code table and packer
// depends on hcbp_pkg, hcbp_code_table and hcbp_packer
// path: an item enters the staged item register with its table read, then the output register
// throughput: one item per cycle while the staged item is not held; an item gives up to 4 bytes,
// so the byte output port at one byte per cycle when not stalled sets the sustained rate
// reset: clears all table valid bits at once (every lookup reads with hit low), pending bits and stages
module huffman_code_bit_packer #(
    parameter int SYMBOL_COUNT = hcbp_pkg::HCBP_SYMBOL_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  hcbp_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output hcbp_pkg::t_out_item o_item
);
    import hcbp_pkg::*;

    localparam int AW = $clog2(SYMBOL_COUNT);

    logic                  r_s1_valid;
    t_func                 r_s1_func;
    logic                  accept;
    logic                  in_range;
    logic                  adv;
    logic [HCBP_LEN_W-1:0] sat_len;
    logic [31:0]           len_mask;
    t_code_entry           wr_entry;
    t_tbl_rd               tbl_rd;

    // input transfer and symbol range check
    assign accept   = i_valid && !o_stall;
    assign in_range = ({1'b0, i_item.symbol} < 9'(SYMBOL_COUNT));
    assign o_stall  = r_s1_valid && !adv;

    // saturate loaded length and keep only its low code bits
    always_comb begin
        sat_len = (i_item.code_len > HCBP_LEN_W'(HCBP_LEN_CAP)) ?
                  HCBP_LEN_W'(HCBP_LEN_CAP) : i_item.code_len;
        len_mask           = 32'((33'd1 << sat_len) - 33'd1);
        wr_entry.code_len  = sat_len;
        wr_entry.code_word = i_item.code_bits & len_mask;
    end

    // staged item: function alongside the registered table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_func <= t_func'(i_item.func);
        end
    end

    hcbp_code_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .AW           (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (accept && (t_func'(i_item.func) == FUNC_LOAD) && in_range),
        .i_wr_addr  (i_item.symbol[AW-1:0]),
        .i_wr_entry (wr_entry),
        .i_rd_en    (accept),
        .i_rd_ok    (in_range),
        .i_rd_addr  (i_item.symbol[AW-1:0]),
        .o_rd       (tbl_rd)
    );

    hcbp_packer u_packer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (r_s1_valid),
        .i_func     (r_s1_func),
        .i_tbl      (tbl_rd),
        .o_adv      (adv),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

endmodule

[rtl/hcbp_checker.sv]
// hcbp_checker: port-level assertions for the huffman code bit packer
// depends on hcbp_pkg; bound to huffman_code_bit_packer below
module hcbp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input hcbp_pkg::t_in_item  i_item,
    input logic                o_valid,
    input logic                i_stall,
    input hcbp_pkg::t_out_item o_item
);
    import hcbp_pkg::*;

    // a held result keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("held result changed");

    // a stalled input transfer keeps its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_item))
        else $error("stalled input item changed");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

    // bytes of one item follow each other without a gap
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_item.last |=> o_valid)
        else $error("gap inside a multi-byte result");

    // input is only held back while a result is waiting
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);
